/* sv/indexed_min_heap_decrease_key_top_assert.svh */
// Assertion macros shared by the heap control logic.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_TOP_ASSERT_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_TOP_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define IMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define IMH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/imhdk_pkg.sv */
// ----------------------------------------------------------------------------
// imhdk_pkg
// Types, codes and defaults of the indexed min-heap with decrease-key.
// ----------------------------------------------------------------------------
package imhdk_pkg;

  localparam int unsigned NodesDef      = 256;
  localparam int unsigned WeightBitsDef = 32;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DECREASED = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_POLLED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POS_WAIT,
    S_KEY_WAIT,
    S_UP,
    S_POLL_CMP,
    S_DOWN,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] popped_weight;
    logic [7:0]         popped_node;
    logic [8:0]         entry_count;
  } res_t;

endpackage

/* sv/imhdk_heap_mem.sv */
// ----------------------------------------------------------------------------
// imhdk_heap_mem
// Heap slot storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module imhdk_heap_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 40
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  output logic [DW-1:0] rdata_a_o,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

/* sv/imhdk_pos_mem.sv */
// ----------------------------------------------------------------------------
// imhdk_pos_mem
// Node to heap slot map: one write port, one registered read port.
// ----------------------------------------------------------------------------
module imhdk_pos_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* sv/imhdk_ctrl.sv */
// ----------------------------------------------------------------------------
// imhdk_ctrl
// Command sequencer: insert, decrease-key, poll, sift up and sift down over
// the slot and position memories. The moving entry is held in a register and
// written once at its final slot.
// ----------------------------------------------------------------------------
`include "indexed_min_heap_decrease_key_top_assert.svh"

module imhdk_ctrl #(
  parameter int unsigned NODES       = imhdk_pkg::NodesDef,
  parameter int unsigned WEIGHT_BITS = imhdk_pkg::WeightBitsDef,
  localparam int unsigned IW = $clog2(NODES),
  localparam int unsigned SW = $clog2(NODES + 1),
  localparam int unsigned PN = (NODES < 256) ? NODES : 256,
  localparam int unsigned PW = $clog2(PN),
  localparam int unsigned DW = WEIGHT_BITS + 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  logic [7:0]            node_id_i,
  input  logic signed [31:0]    key_weight_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output imhdk_pkg::res_t       res_o,
  output logic                  heap_we_o,
  output logic [IW-1:0]         heap_waddr_o,
  output logic [DW-1:0]         heap_wdata_o,
  output logic [IW-1:0]         heap_raddr_a_o,
  input  logic [DW-1:0]         heap_rdata_a_i,
  output logic [IW-1:0]         heap_raddr_b_o,
  input  logic [DW-1:0]         heap_rdata_b_i,
  output logic                  pos_we_o,
  output logic [PW-1:0]         pos_waddr_o,
  output logic [IW-1:0]         pos_wdata_o,
  output logic [PW-1:0]         pos_raddr_o,
  input  logic [IW-1:0]         pos_rdata_i
);

  localparam int unsigned CW = IW + 2;

  imhdk_pkg::state_e state_q, state_d;
  logic [SW-1:0]     size_q, size_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic signed [WEIGHT_BITS-1:0] mw_q, mw_d;
  logic [7:0]        mn_q, mn_d;
  logic [PN-1:0]     present_q, present_d;
  imhdk_pkg::res_t   res_q, res_d;

  logic signed [WEIGHT_BITS-1:0] a_w, b_w;
  logic [7:0]        a_n, b_n;
  logic [IW-1:0]     parent;
  logic [CW-1:0]     lchild, rchild, best;
  logic              l_ok, r_ok, take_l, take_r;
  logic signed [WEIGHT_BITS-1:0] best_w;
  logic              in_range, ins_acc;

  assign a_w = heap_rdata_a_i[WEIGHT_BITS-1:0];
  assign a_n = heap_rdata_a_i[DW-1:WEIGHT_BITS];
  assign b_w = heap_rdata_b_i[WEIGHT_BITS-1:0];
  assign b_n = heap_rdata_b_i[DW-1:WEIGHT_BITS];

  assign parent = IW'((idx_q - 1'b1) >> 1);
  assign lchild = {1'b0, idx_q, 1'b1};
  assign rchild = lchild + 1'b1;
  assign l_ok   = 32'(lchild) < 32'(size_q);
  assign r_ok   = 32'(rchild) < 32'(size_q);

  // Left child first, strict compares on both.
  always_comb begin
    take_l = l_ok && (a_w < mw_q);
    best_w = take_l ? a_w : mw_q;
    take_r = r_ok && (b_w < best_w);
    best   = take_r ? rchild : lchild;
  end

  assign in_range = 32'(node_id_i) < 32'(NODES);
  assign ins_acc  = (state_q == imhdk_pkg::S_IDLE) && in_valid_i &&
                    (cmd_i == imhdk_pkg::CMD_ADD) && in_range &&
                    !present_q[node_id_i[PW-1:0]];

  assign in_ready_o  = (state_q == imhdk_pkg::S_IDLE);
  assign res_valid_o = (state_q == imhdk_pkg::S_DONE);
  assign res_o       = res_q;

  always_comb begin
    state_d        = state_q;
    size_d         = size_q;
    idx_d          = idx_q;
    mw_d           = mw_q;
    mn_d           = mn_q;
    present_d      = present_q;
    res_d          = res_q;
    heap_we_o      = 1'b0;
    heap_waddr_o   = idx_q;
    heap_wdata_o   = {mn_q, mw_q};
    heap_raddr_a_o = '0;
    heap_raddr_b_o = '0;
    pos_we_o       = 1'b0;
    pos_waddr_o    = mn_q[PW-1:0];
    pos_wdata_o    = idx_q;
    pos_raddr_o    = node_id_i[PW-1:0];

    unique case (state_q)
      imhdk_pkg::S_IDLE: begin
        if (cmd_i == imhdk_pkg::CMD_POLL) begin
          heap_raddr_a_o = '0;
          heap_raddr_b_o = IW'(size_q - 1'b1);
        end else begin
          heap_raddr_a_o = IW'((size_q - 1'b1) >> 1);
        end
        if (in_valid_i) begin
          mw_d = key_weight_i[WEIGHT_BITS-1:0];
          mn_d = node_id_i;
          res_d.popped_weight = '0;
          res_d.popped_node   = '0;
          res_d.entry_count   = 9'(size_q);
          if (cmd_i == imhdk_pkg::CMD_POLL) begin
            if (size_q == '0) begin
              res_d.status = imhdk_pkg::ST_EMPTY;
              state_d      = imhdk_pkg::S_DONE;
            end else begin
              state_d = imhdk_pkg::S_POLL_CMP;
            end
          end else if (!in_range) begin
            res_d.status = imhdk_pkg::ST_IGNORED;
            state_d      = imhdk_pkg::S_DONE;
          end else if (!present_q[node_id_i[PW-1:0]]) begin
            present_d[node_id_i[PW-1:0]] = 1'b1;
            size_d             = SW'(size_q + 1'b1);
            idx_d              = IW'(size_q);
            res_d.status       = imhdk_pkg::ST_INSERTED;
            res_d.entry_count  = 9'(size_q + 1'b1);
            state_d            = imhdk_pkg::S_UP;
          end else begin
            res_d.status = imhdk_pkg::ST_DECREASED;
            state_d      = imhdk_pkg::S_POS_WAIT;
          end
        end
      end

      imhdk_pkg::S_POS_WAIT: begin
        heap_raddr_a_o = pos_rdata_i;
        idx_d          = pos_rdata_i;
        state_d        = imhdk_pkg::S_KEY_WAIT;
      end

      imhdk_pkg::S_KEY_WAIT: begin
        heap_raddr_a_o = parent;
        if (mw_q < a_w) begin
          state_d = imhdk_pkg::S_UP;
        end else begin
          res_d.status = imhdk_pkg::ST_IGNORED;
          state_d      = imhdk_pkg::S_DONE;
        end
      end

      // Read data holds the parent of idx_q; one level per cycle.
      imhdk_pkg::S_UP: begin
        heap_we_o = 1'b1;
        pos_we_o  = 1'b1;
        if (idx_q == '0 || !(a_w > mw_q)) begin
          state_d = imhdk_pkg::S_DONE;
        end else begin
          heap_wdata_o   = heap_rdata_a_i;
          pos_waddr_o    = a_n[PW-1:0];
          idx_d          = parent;
          heap_raddr_a_o = IW'((parent - 1'b1) >> 1);
        end
      end

      imhdk_pkg::S_POLL_CMP: begin
        res_d.status        = imhdk_pkg::ST_POLLED;
        res_d.popped_weight = 32'(a_w);
        res_d.popped_node   = a_n;
        res_d.entry_count   = 9'(size_q - 1'b1);
        present_d[a_n[PW-1:0]] = 1'b0;
        size_d = SW'(size_q - 1'b1);
        if (size_q == SW'(1)) begin
          state_d = imhdk_pkg::S_DONE;
        end else begin
          mw_d           = b_w;
          mn_d           = b_n;
          idx_d          = '0;
          heap_raddr_a_o = IW'(1);
          heap_raddr_b_o = IW'(2);
          state_d        = imhdk_pkg::S_DOWN;
        end
      end

      // Read ports hold the left and right child of idx_q.
      imhdk_pkg::S_DOWN: begin
        heap_we_o = 1'b1;
        pos_we_o  = 1'b1;
        if (!take_l && !take_r) begin
          state_d = imhdk_pkg::S_DONE;
        end else begin
          heap_wdata_o   = take_r ? heap_rdata_b_i : heap_rdata_a_i;
          pos_waddr_o    = take_r ? b_n[PW-1:0] : a_n[PW-1:0];
          idx_d          = IW'(best);
          heap_raddr_a_o = IW'({best, 1'b1});
          heap_raddr_b_o = IW'({best, 1'b1} + 1'b1);
        end
      end

      imhdk_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = imhdk_pkg::S_IDLE;
        end
      end

      default: state_d = imhdk_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= imhdk_pkg::S_IDLE;
      size_q    <= '0;
      present_q <= '0;
    end else begin
      state_q   <= state_d;
      size_q    <= size_d;
      present_q <= present_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    mw_q  <= mw_d;
    mn_q  <= mn_d;
    res_q <= res_d;
  end

  `IMH_ASSERT(a_size_cap, 32'(size_q) <= 32'(PN), "heap size beyond capacity")
  `IMH_ASSERT_NEXT(a_ins_grow, ins_acc, size_q == SW'($past(size_q) + 1'b1), "insert lost")
  `IMH_ASSERT(a_idle_no_wr, (state_q == imhdk_pkg::S_IDLE) |-> (!heap_we_o && !pos_we_o),
              "memory write while idle")

endmodule

/* sv/indexed_min_heap_decrease_key_top.sv */
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_top
// Indexed binary min-heap of (weight, node) entries with decrease-key.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): cmd_i 0 adds a node or lowers its
// weight, cmd_i 1 polls the minimum. Output channel (out_valid_o/out_ready_i)
// returns one item per command: status, popped entry, entry count.
// Commands run one at a time. Heap slots sit in a memory with two registered
// read ports, the node-to-slot map in a second memory; sift up and sift down
// take one cycle per heap level. An insert sifts up at once; a decrease first
// reads the node's slot and then its key, and a poll first reads the root and
// the last entry before it sifts down (at most log2(NODES) levels walked).
// The result sits in an output register; the next item is taken as soon as
// it is loaded. If the receiver stalls with a result still held, the next
// finished item waits in the sequencer and no further item is accepted.
// Reset clears the heap size and the presence bits; memories need no clear.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key_top #(
  parameter int unsigned NODES       = imhdk_pkg::NodesDef,
  parameter int unsigned WEIGHT_BITS = imhdk_pkg::WeightBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [7:0]         node_id_i,
  input  logic signed [31:0] key_weight_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] popped_weight_o,
  output logic [7:0]         popped_node_o,
  output logic [8:0]         entry_count_o
);

  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned PN = (NODES < 256) ? NODES : 256;
  localparam int unsigned PW = $clog2(PN);
  localparam int unsigned DW = WEIGHT_BITS + 8;

  logic            heap_we;
  logic [IW-1:0]   heap_waddr, heap_raddr_a, heap_raddr_b;
  logic [DW-1:0]   heap_wdata, heap_rdata_a, heap_rdata_b;
  logic            pos_we;
  logic [PW-1:0]   pos_waddr, pos_raddr;
  logic [IW-1:0]   pos_wdata, pos_rdata;
  logic            res_valid, slot_free;
  imhdk_pkg::res_t res;

  logic            out_valid_q;
  imhdk_pkg::res_t out_q;

  assign slot_free = !out_valid_q || out_ready_i;

  imhdk_heap_mem #(.DEPTH(NODES), .AW(IW), .DW(DW)) u_heap_mem (
    .clk_i     (clk_i),
    .we_i      (heap_we),
    .waddr_i   (heap_waddr),
    .wdata_i   (heap_wdata),
    .raddr_a_i (heap_raddr_a),
    .rdata_a_o (heap_rdata_a),
    .raddr_b_i (heap_raddr_b),
    .rdata_b_o (heap_rdata_b)
  );

  imhdk_pos_mem #(.DEPTH(PN), .AW(PW), .DW(IW)) u_pos_mem (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  imhdk_ctrl #(.NODES(NODES), .WEIGHT_BITS(WEIGHT_BITS)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .node_id_i      (node_id_i),
    .key_weight_i   (key_weight_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (slot_free),
    .res_o          (res),
    .heap_we_o      (heap_we),
    .heap_waddr_o   (heap_waddr),
    .heap_wdata_o   (heap_wdata),
    .heap_raddr_a_o (heap_raddr_a),
    .heap_rdata_a_i (heap_rdata_a),
    .heap_raddr_b_o (heap_raddr_b),
    .heap_rdata_b_i (heap_rdata_b),
    .pos_we_o       (pos_we),
    .pos_waddr_o    (pos_waddr),
    .pos_wdata_o    (pos_wdata),
    .pos_raddr_o    (pos_raddr),
    .pos_rdata_i    (pos_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign popped_weight_o = out_q.popped_weight;
  assign popped_node_o   = out_q.popped_node;
  assign entry_count_o   = out_q.entry_count;

endmodule
